FILE: rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types, codes and helper functions for the sensor record logger.
// ----------------------------------------------------------------------------
package slr_pkg;

  // log memory and record geometry
  localparam int MaxCapacity    = 8192;
  localparam int MaxRecordBytes = 16;
  localparam int AddrW          = 13;
  localparam int PtrW           = 14;
  localparam int BeatW          = 4;
  localparam int StrideW        = 5;
  localparam int RecW           = MaxRecordBytes * 8;

  // configuration register indexes
  localparam logic [1:0] CFG_MASK     = 2'd0;
  localparam logic [1:0] CFG_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_START    = 2'd2;

  // log states
  localparam logic [1:0] LOG_STOPPED = 2'd0;
  localparam logic [1:0] LOG_RUNNING = 2'd1;
  localparam logic [1:0] LOG_FULL    = 2'd2;
  localparam logic [1:0] LOG_ERROR   = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_STATE   = 3'd1;
  localparam logic [2:0] ST_POINTER = 3'd2;
  localparam logic [2:0] ST_CONFIG  = 3'd3;
  localparam logic [2:0] ST_SPACE   = 3'd4;

  // request types
  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // sample limits
  localparam logic [7:0]  SUPPLY_NONE = 8'd255;
  localparam logic [7:0]  SUPPLY_MAX  = 8'd15;
  localparam logic [15:0] LIGHT_MAX   = 16'd4095;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic decide;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic last_beat;
  } sts_t;

  // record stride in bytes, zero for an invalid mask
  function automatic logic [StrideW-1:0] stride_of(input logic [7:0] mask);
    logic [StrideW-1:0] n;
    n = 5'd1;
    if (mask[0]) n = n + 5'd2;
    if (mask[1]) n = n + 5'd2;
    if (mask[2]) n = n + 5'd2;
    if (mask[3]) n = n + 5'd6;
    if (mask == 8'd0 || mask[7:4] != 4'd0) begin
      stride_of = '0;
    end else begin
      stride_of = (n + 5'd3) & ~5'd3;
    end
  endfunction

  function automatic logic capacity_ok(input logic [PtrW-1:0] cap);
    capacity_ok = (cap == 14'd512) || (cap == 14'd2048) || (cap == 14'd8192);
  endfunction

  // base-4 digit sum keeps the residue mod 3
  function automatic logic mod3_zero(input logic [PtrW-1:0] v);
    logic [4:0] sum;
    sum = '0;
    for (int i = 0; i < PtrW / 2; i++) begin
      sum = sum + {3'd0, v[2*i +: 2]};
    end
    mod3_zero = sum inside {5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21};
  endfunction

  // supply byte, then enabled 16-bit fields little-endian, zero padded
  function automatic logic [RecW-1:0] pack_record(input logic [7:0] supply,
                                                  input logic [3:0] mask,
                                                  input logic [95:0] fields);
    logic [RecW-1:0] rec;
    logic [BeatW-1:0] pos;
    logic en;
    rec = '0;
    rec[7:0] = supply;
    pos = 4'd1;
    for (int i = 0; i < 6; i++) begin
      en = mask[(i < 3) ? i : 3];
      if (en) begin
        rec[{pos, 3'b000} +: 16] = fields[16*i +: 16];
        pos = pos + 4'd2;
      end
    end
    pack_record = rec;
  endfunction

endpackage

FILE: rtl/slr_ctrl.sv
// ----------------------------------------------------------------------------
// slr_ctrl
// Sequencer: takes one request, has it checked, then steps out its beats.
// ----------------------------------------------------------------------------
module slr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output slr_pkg::cmd_t cmd,
  input  slr_pkg::sts_t sts
);
  import slr_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.last_beat) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/slr_datapath.sv
// ----------------------------------------------------------------------------
// slr_datapath
// Config and log registers, request checks, record packing and output beat.
// ----------------------------------------------------------------------------
module slr_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  slr_pkg::cmd_t         cmd,
  output slr_pkg::sts_t         sts,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [13:0]           cfg_wdata,
  input  logic                  req_type,
  input  logic [7:0]            supply,
  input  logic signed [15:0]    old_temp,
  input  logic signed [15:0]    precise_temp,
  input  logic [15:0]           light,
  input  logic signed [15:0]    accel_x,
  input  logic signed [15:0]    accel_y,
  input  logic signed [15:0]    accel_z,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  byte_valid,
  output logic [12:0]           address,
  output logic [7:0]            data_byte,
  output logic                  last,
  output logic [2:0]            status,
  output logic [1:0]            log_state
);
  import slr_pkg::*;

  // configuration
  logic [7:0]       sensor_mask;
  logic [PtrW-1:0]  capacity;
  logic [AddrW-1:0] log_start;

  // log state
  logic [PtrW-1:0]  write_pointer;
  logic [1:0]       run_state;

  // latched request
  logic             req_q;
  logic [7:0]       supply_q;
  logic [95:0]      fields_q;

  // beat sequencing
  logic             single_q;
  logic [2:0]       status_q;
  logic [RecW-1:0]  rec_q;
  logic [AddrW-1:0] addr_q;
  logic [BeatW-1:0] beat_idx;
  logic [BeatW-1:0] stride_m1;

  // checks
  logic [StrideW-1:0] stride;
  logic               mask_ok;
  logic               cap_ok;
  logic               ptr_ok;
  logic               sample_bad;
  logic [PtrW-1:0]    diff;
  logic               diff_ok;
  logic [PtrW:0]      sum_one;
  logic [PtrW:0]      sum_two;
  logic [15:0]        light_q;

  // decision
  logic               dec_single;
  logic [2:0]         dec_status;
  logic [1:0]         dec_state;
  logic [PtrW-1:0]    dec_wp;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_mask <= 8'd0;
      capacity    <= PtrW'(MaxCapacity);
      log_start   <= 13'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASK:     sensor_mask <= cfg_wdata[7:0];
        CFG_CAPACITY: capacity    <= cfg_wdata;
        CFG_START:    log_start   <= cfg_wdata[AddrW-1:0];
        default:      ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q    <= req_type;
      supply_q <= supply;
      fields_q <= {accel_z, accel_y, accel_x, light, precise_temp, old_temp};
    end
  end

  assign light_q = fields_q[47:32];
  assign stride  = stride_of(sensor_mask);
  assign mask_ok = (stride != '0);
  assign cap_ok  = capacity_ok(capacity);

  // pointer must be a whole number of strides past the start
  assign diff = write_pointer - {1'b0, log_start};
  always_comb begin
    case (stride)
      5'd4:    diff_ok = (diff[1:0] == 2'd0);
      5'd8:    diff_ok = (diff[2:0] == 3'd0);
      5'd12:   diff_ok = (diff[1:0] == 2'd0) && mod3_zero(diff);
      5'd16:   diff_ok = (diff[3:0] == 4'd0);
      default: diff_ok = (write_pointer == {1'b0, log_start});
    endcase
  end

  assign ptr_ok = (write_pointer >= {1'b0, log_start}) && (write_pointer <= capacity)
               && (write_pointer[1:0] == 2'd0) && diff_ok;

  assign sample_bad = ((supply_q > SUPPLY_MAX) && (supply_q != SUPPLY_NONE))
                   || ((sensor_mask[2:0] != 3'd0) ? (supply_q == SUPPLY_NONE)
                                                  : (supply_q != SUPPLY_NONE))
                   || (sensor_mask[2] && (light_q > LIGHT_MAX));

  // space before and after this record
  assign sum_one = {1'b0, write_pointer} + {10'd0, stride};
  assign sum_two = sum_one + {10'd0, stride};

  // outcome of the request
  always_comb begin
    dec_single = 1'b1;
    dec_status = ST_OK;
    dec_state  = run_state;
    dec_wp     = write_pointer;
    if (req_q == REQ_RESTART) begin
      if (!mask_ok || !cap_ok) begin
        dec_status = ST_CONFIG;
        dec_state  = LOG_ERROR;
      end else begin
        dec_state = LOG_RUNNING;
        dec_wp    = {1'b0, log_start};
      end
    end else if (run_state != LOG_RUNNING) begin
      dec_status = ST_STATE;
    end else if (!ptr_ok) begin
      dec_status = ST_POINTER;
      dec_state  = LOG_ERROR;
    end else if (!mask_ok || !cap_ok || sample_bad) begin
      dec_status = ST_CONFIG;
      dec_state  = LOG_ERROR;
    end else if (sum_one > {1'b0, capacity}) begin
      dec_status = ST_SPACE;
      dec_state  = LOG_FULL;
    end else begin
      dec_single = 1'b0;
      dec_wp     = sum_one[PtrW-1:0];
      dec_state  = (sum_two > {1'b0, capacity}) ? LOG_FULL : LOG_RUNNING;
    end
  end

  // log state update
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      run_state     <= LOG_STOPPED;
    end else if (cmd.decide) begin
      write_pointer <= dec_wp;
      run_state     <= dec_state;
    end
  end

  // record and beat counters
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      single_q  <= dec_single;
      status_q  <= dec_status;
      rec_q     <= pack_record(supply_q, sensor_mask[3:0], fields_q);
      addr_q    <= write_pointer[AddrW-1:0];
      beat_idx  <= '0;
      stride_m1 <= BeatW'(stride - 5'd1);
    end else if (cmd.emit) begin
      rec_q    <= rec_q >> 8;
      addr_q   <= addr_q + 13'd1;
      beat_idx <= beat_idx + 4'd1;
    end
  end

  assign sts.slot_free = !out_valid || out_ready;
  assign sts.last_beat = single_q || (beat_idx == stride_m1);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      log_state <= run_state;
      if (single_q) begin
        byte_valid <= 1'b0;
        address    <= '0;
        data_byte  <= 8'd0;
        last       <= 1'b1;
        status     <= status_q;
      end else begin
        byte_valid <= 1'b1;
        address    <= addr_q;
        data_byte  <= rec_q[7:0];
        last       <= (beat_idx == stride_m1);
        status     <= ST_OK;
      end
    end
  end

endmodule

FILE: rtl/sensor_record_logger.sv
// ----------------------------------------------------------------------------
// sensor_record_logger
// Packs sensor samples into fixed-stride records and writes them byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready): one request per beat, either a sample to
//   append or a restart that rewinds the log to log_start and sets it running.
//   out channel (out_valid/out_ready): one beat per record byte with its log
//   address, or a single beat with byte_valid low carrying the status code.
//   last marks the final beat of each request; log_state is the state after it.
//   config port: cfg_we writes cfg_wdata into register cfg_index (0 mask,
//   1 capacity, 2 log start); write only while no request is in flight.
// Timing:
//   a request is captured, then checked, then stepped out one beat per cycle
//   (4, 8, 12 or 16 bytes, or 1 status beat) while the receiver takes each beat.
//   the next request is accepted as soon as the final beat is loaded.
// Reset: log stopped, pointer zero, mask 0, capacity 8192, log start 128.
// A stalled receiver holds the output register and freezes the beat sequencer.
// ----------------------------------------------------------------------------
module sensor_record_logger (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [13:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [7:0]         supply,
  input  logic signed [15:0] old_temp,
  input  logic signed [15:0] precise_temp,
  input  logic [15:0]        light,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               byte_valid,
  output logic [12:0]        address,
  output logic [7:0]         data_byte,
  output logic               last,
  output logic [2:0]         status,
  output logic [1:0]         log_state
);
  import slr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  slr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // checks, packing and output beat
  slr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .req_type     (req_type),
    .supply       (supply),
    .old_temp     (old_temp),
    .precise_temp (precise_temp),
    .light        (light),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .byte_valid   (byte_valid),
    .address      (address),
    .data_byte    (data_byte),
    .last         (last),
    .status       (status),
    .log_state    (log_state)
  );

endmodule
